/* src/usbmidi_pkg.sv */
package usbmidi_pkg;

    // Width of the SysEx fill index and message length.
    localparam int FILL_W = 7;
    // Depth of the queue between the front and back parts.
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W = $clog2(QUEUE_DEPTH);

    localparam logic [7:0] NIBBLE_MASK = 8'h0F;
    localparam logic [7:0] SYSEX_END_BYTE = 8'hF7;

    // Code index numbers.
    localparam logic [3:0] CODE_SYS_COMMON2 = 4'h2;
    localparam logic [3:0] CODE_SYS_COMMON3 = 4'h3;
    localparam logic [3:0] CODE_SYSEX_START = 4'h4;
    localparam logic [3:0] CODE_SYSEX_END1 = 4'h5;
    localparam logic [3:0] CODE_SYSEX_END2 = 4'h6;
    localparam logic [3:0] CODE_SYSEX_END3 = 4'h7;
    localparam logic [3:0] CODE_NOTE_RELEASE = 4'h8;
    localparam logic [3:0] CODE_NOTE_START = 4'h9;
    localparam logic [3:0] CODE_CTRL_CHANGE = 4'hB;
    localparam logic [3:0] CODE_PROG_CHANGE = 4'hC;
    localparam logic [3:0] CODE_AFTERTOUCH = 4'hD;
    localparam logic [3:0] CODE_BEND_WHEEL = 4'hE;
    localparam logic [3:0] CODE_ONE_BYTE = 4'hF;

    typedef enum logic [3:0] {
        KIND_NOTE_ON     = 4'd0,
        KIND_NOTE_OFF    = 4'd1,
        KIND_CC          = 4'd2,
        KIND_PROGRAM     = 4'd3,
        KIND_BEND        = 4'd4,
        KIND_PRESSURE    = 4'd5,
        KIND_SYS_COMMON  = 4'd6,
        KIND_SINGLE_BYTE = 4'd7,
        KIND_SYSEX_BYTE  = 4'd8,
        KIND_OVERFLOW    = 4'd9,
        KIND_UNSUPPORTED = 4'd10
    } t_kind;

    // What the back part does with a queued packet.
    typedef enum logic [1:0] {
        OP_EMIT   = 2'd0,
        OP_APPEND = 2'd1,
        OP_END    = 2'd2
    } t_op;

    typedef enum logic [1:0] {
        ST_IDLE   = 2'd0,
        ST_APPEND = 2'd1,
        ST_READ   = 2'd2,
        ST_EMIT   = 2'd3
    } t_back_state;

    typedef struct packed {
        logic [7:0] packet_header;
        logic [7:0] byte0;
        logic [7:0] byte1;
        logic [7:0] byte2;
    } t_in_req;

    typedef struct packed {
        logic [3:0]        event_kind;
        logic [4:0]        channel_number;
        logic [7:0]        out_status;
        logic [7:0]        out_data1;
        logic [7:0]        out_data2;
        logic [7:0]        sysex_byte;
        logic [FILL_W-1:0] message_length;
        logic              last_of_run;
    } t_out_req;

    // A classified packet as it travels through the queue.
    typedef struct packed {
        t_op        op;
        t_kind      kind;
        logic [1:0] nbytes;
        logic [7:0] byte0;
        logic [7:0] byte1;
        logic [7:0] byte2;
    } t_cmd;

    // Builds one result request from a classified packet.
    function automatic t_out_req make_result(t_kind kind, t_cmd cmd, logic [7:0] sx,
                                             logic [FILL_W-1:0] len, logic last);
        t_out_req r;
        r.event_kind     = kind;
        r.channel_number = {1'b0, cmd.byte0[3:0] & NIBBLE_MASK[3:0]} + 5'd1;
        r.out_status     = cmd.byte0;
        r.out_data1      = cmd.byte1;
        r.out_data2      = cmd.byte2;
        r.sysex_byte     = sx;
        r.message_length = len;
        r.last_of_run    = last;
        return r;
    endfunction

endpackage

/* src/usbmidi_ram.sv */
module usbmidi_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // One write port and one registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* src/usbmidi_front.sv */
module usbmidi_front (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_in_valid,
    output logic                   o_in_stall,
    input  usbmidi_pkg::t_in_req   i_in,
    output logic                   o_q_push,
    output usbmidi_pkg::t_cmd      o_q_cmd,
    input  logic                   i_q_full
);

    import usbmidi_pkg::*;

    logic r_valid;
    logic n_valid;
    t_cmd r_cmd;
    t_cmd n_cmd;
    t_cmd cls;
    logic load;

    // Decode the code index number into an operation and a result kind.
    always_comb begin
        cls.op     = OP_EMIT;
        cls.kind   = KIND_UNSUPPORTED;
        cls.nbytes = 2'd0;
        cls.byte0  = i_in.byte0;
        cls.byte1  = i_in.byte1;
        cls.byte2  = i_in.byte2;
        case (i_in.packet_header[3:0] & NIBBLE_MASK[3:0])
            CODE_NOTE_START:   cls.kind = KIND_NOTE_ON;
            CODE_NOTE_RELEASE: cls.kind = KIND_NOTE_OFF;
            CODE_CTRL_CHANGE:  cls.kind = KIND_CC;
            CODE_PROG_CHANGE:  cls.kind = KIND_PROGRAM;
            CODE_BEND_WHEEL:   cls.kind = KIND_BEND;
            CODE_AFTERTOUCH:   cls.kind = KIND_PRESSURE;
            CODE_SYS_COMMON2:  cls.kind = KIND_SYS_COMMON;
            CODE_SYS_COMMON3:  cls.kind = KIND_SYS_COMMON;
            CODE_ONE_BYTE:     cls.kind = KIND_SINGLE_BYTE;
            CODE_SYSEX_START: begin
                cls.op     = OP_APPEND;
                cls.nbytes = 2'd3;
            end
            CODE_SYSEX_END3: begin
                cls.op     = OP_END;
                cls.nbytes = 2'd3;
            end
            CODE_SYSEX_END2: begin
                cls.op     = OP_END;
                cls.nbytes = 2'd2;
            end
            CODE_SYSEX_END1: begin
                // A one-byte packet that is not an end of exclusive is system common.
                if (i_in.byte0 != SYSEX_END_BYTE) begin
                    cls.kind = KIND_SYS_COMMON;
                end else begin
                    cls.op     = OP_END;
                    cls.nbytes = 2'd1;
                end
            end
            default: cls.kind = KIND_UNSUPPORTED;
        endcase
    end

    // One holding register in front of the queue.
    assign o_in_stall = r_valid && i_q_full;
    assign load       = i_in_valid && !o_in_stall;
    assign o_q_push   = r_valid && !i_q_full;
    assign o_q_cmd    = r_cmd;

    always_comb begin
        n_valid = r_valid;
        n_cmd   = r_cmd;
        if (load) begin
            n_valid = 1'b1;
            n_cmd   = cls;
        end else if (o_q_push) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
        r_cmd <= n_cmd;
    end

endmodule

/* src/usbmidi_queue.sv */
module usbmidi_queue (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  usbmidi_pkg::t_cmd i_cmd,
    output logic              o_full,
    input  logic              i_pop,
    output logic              o_valid,
    output usbmidi_pkg::t_cmd o_cmd
);

    import usbmidi_pkg::*;

    t_cmd              r_slot [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wptr;
    logic [QPTR_W-1:0] n_wptr;
    logic [QPTR_W-1:0] r_rptr;
    logic [QPTR_W-1:0] n_rptr;
    logic [QPTR_W:0]   r_count;
    logic [QPTR_W:0]   n_count;
    logic              do_push;
    logic              do_pop;

    assign o_full  = (r_count == (QPTR_W + 1)'(QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_cmd   = r_slot[r_rptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    // Pointer and occupancy update.
    always_comb begin
        n_wptr  = do_push ? r_wptr + 1'b1 : r_wptr;
        n_rptr  = do_pop ? r_rptr + 1'b1 : r_rptr;
        n_count = r_count;
        if (do_push && !do_pop) begin
            n_count = r_count + 1'b1;
        end else if (do_pop && !do_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
            r_count <= n_count;
        end
        if (do_push) begin
            r_slot[r_wptr] <= i_cmd;
        end
    end

endmodule

/* src/usbmidi_back.sv */
module usbmidi_back #(
    parameter int SYSEX_MAX = 64
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_q_valid,
    input  usbmidi_pkg::t_cmd     i_q_cmd,
    output logic                  o_q_pop,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output usbmidi_pkg::t_out_req o_out
);

    import usbmidi_pkg::*;

    localparam int AW = $clog2(SYSEX_MAX);
    localparam logic [FILL_W-1:0] ROOM_APPEND = FILL_W'(SYSEX_MAX - 4);
    localparam logic [FILL_W-1:0] ROOM_END = FILL_W'(SYSEX_MAX - 1);

    t_back_state       r_state;
    t_back_state       n_state;
    logic [FILL_W-1:0] r_fill;
    logic [FILL_W-1:0] n_fill;
    logic [FILL_W-1:0] r_rd_idx;
    logic [FILL_W-1:0] n_rd_idx;
    logic [1:0]        r_cnt;
    logic [1:0]        n_cnt;
    t_cmd              r_cmd;
    t_cmd              n_cmd;
    logic              r_out_valid;
    logic              n_out_valid;
    t_out_req          r_out;
    t_out_req          n_out;

    logic              out_free;
    logic              room_append;
    logic              room_end;
    logic              drain_last;
    logic              ram_we;
    logic [7:0]        ram_wdata;
    logic [7:0]        ram_rdata;

    assign out_free    = !r_out_valid || !i_out_stall;
    assign room_append = r_fill < ROOM_APPEND;
    assign room_end    = r_fill < (ROOM_END - FILL_W'(i_q_cmd.nbytes));
    assign drain_last  = (r_rd_idx + 1'b1) == r_fill;

    // SysEx byte store.
    usbmidi_ram #(
        .WIDTH(8),
        .DEPTH(SYSEX_MAX)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_fill[AW-1:0]),
        .i_wdata (ram_wdata),
        .i_raddr (r_rd_idx[AW-1:0]),
        .o_rdata (ram_rdata)
    );

    // Byte of the packet being appended.
    always_comb begin
        case (r_cnt)
            2'd0:    ram_wdata = r_cmd.byte0;
            2'd1:    ram_wdata = r_cmd.byte1;
            default: ram_wdata = r_cmd.byte2;
        endcase
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_q_valid) begin
                    if (i_q_cmd.op == OP_APPEND && room_append) begin
                        n_state = ST_APPEND;
                    end else if (i_q_cmd.op == OP_END && room_end) begin
                        n_state = ST_APPEND;
                    end
                end
            end
            ST_APPEND: begin
                if (r_cnt == r_cmd.nbytes - 2'd1) begin
                    n_state = (r_cmd.op == OP_END) ? ST_READ : ST_IDLE;
                end
            end
            ST_READ: n_state = ST_EMIT;
            ST_EMIT: begin
                if (out_free) begin
                    n_state = drain_last ? ST_IDLE : ST_READ;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Datapath, queue pop, store write and result register.
    always_comb begin
        n_fill      = r_fill;
        n_rd_idx    = r_rd_idx;
        n_cnt       = r_cnt;
        n_cmd       = r_cmd;
        n_out_valid = r_out_valid && i_out_stall;
        n_out       = r_out;
        o_q_pop     = 1'b0;
        ram_we      = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (i_q_valid) begin
                    case (i_q_cmd.op)
                        OP_APPEND: begin
                            // A start or continue packet without room is dropped.
                            o_q_pop = 1'b1;
                            n_cmd   = i_q_cmd;
                            n_cnt   = 2'd0;
                        end
                        OP_END: begin
                            if (room_end) begin
                                o_q_pop = 1'b1;
                                n_cmd   = i_q_cmd;
                                n_cnt   = 2'd0;
                            end else if (out_free) begin
                                o_q_pop     = 1'b1;
                                n_fill      = '0;
                                n_out_valid = 1'b1;
                                n_out       = make_result(KIND_OVERFLOW, i_q_cmd, 8'd0,
                                                          '0, 1'b1);
                            end
                        end
                        default: begin
                            if (out_free) begin
                                o_q_pop     = 1'b1;
                                n_out_valid = 1'b1;
                                n_out       = make_result(i_q_cmd.kind, i_q_cmd, 8'd0,
                                                          '0, 1'b1);
                            end
                        end
                    endcase
                end
            end
            ST_APPEND: begin
                ram_we   = 1'b1;
                n_fill   = r_fill + 1'b1;
                n_cnt    = r_cnt + 2'd1;
                n_rd_idx = '0;
            end
            ST_READ: begin
                // Store read is in flight.
            end
            ST_EMIT: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out       = make_result(KIND_SYSEX_BYTE, r_cmd, ram_rdata, r_fill,
                                              drain_last);
                    if (drain_last) begin
                        n_fill = '0;
                    end else begin
                        n_rd_idx = r_rd_idx + 1'b1;
                    end
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_fill      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_fill      <= n_fill;
            r_out_valid <= n_out_valid;
        end
        r_rd_idx <= n_rd_idx;
        r_cnt    <= n_cnt;
        r_cmd    <= n_cmd;
        r_out    <= n_out;
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule

/* src/usb_midi_packet_decoder_core.sv */
// USB-MIDI event packet decoder.
// Input channel: i_in_valid / o_in_stall carry one 4-byte event packet per request
// (header with cable number and code index number, then three MIDI bytes).
// Output channel: o_out_valid / i_out_stall carry one result request: event kind,
// channel 1..16, the raw MIDI bytes and, for SysEx, one message byte with length.
// A front stage classifies packets into a four-entry queue; the back sequencer
// owns the SysEx store (one write and one registered read port) and the output
// register, so the front keeps taking packets while the back is busy.
// A single-result packet passes the front holding register and the queue to the
// output register; such packets sustain one per cycle while i_out_stall is low.
// SysEx start/continue: the back pops the packet, then makes three store writes.
// SysEx end with n bytes: the back pops it, makes n store writes, then for each
// message byte reads the store (ST_READ) and emits the byte (ST_EMIT); it takes
// no new packet from the queue until the whole message is out.
// Reset clears the fill index, the queue and all valid flags; the store holds
// garbage until written and needs no clearing pass.
// While the receiver stalls, the output request holds; the back stops once it has
// a result to emit, the queue fills and then o_in_stall rises.
module usb_midi_packet_decoder_core #(
    parameter int SYSEX_MAX = 64
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  usbmidi_pkg::t_in_req  i_in,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output usbmidi_pkg::t_out_req o_out
);

    import usbmidi_pkg::*;

    logic q_push;
    logic q_full;
    logic q_pop;
    logic q_valid;
    t_cmd q_in_cmd;
    t_cmd q_out_cmd;

    usbmidi_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in       (i_in),
        .o_q_push   (q_push),
        .o_q_cmd    (q_in_cmd),
        .i_q_full   (q_full)
    );

    usbmidi_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_cmd   (q_in_cmd),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_cmd   (q_out_cmd)
    );

    usbmidi_back #(
        .SYSEX_MAX(SYSEX_MAX)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (q_valid),
        .i_q_cmd     (q_out_cmd),
        .o_q_pop     (q_pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out       (o_out)
    );

    // Every result carries the channel taken from the status byte.
    a_channel: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_out.channel_number == {1'b0, o_out.out_status[3:0]} + 5'd1)
        else $error("channel number does not match status byte");

    // Only SysEx byte results carry a message byte and length.
    a_sysex_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out.event_kind != KIND_SYSEX_BYTE |->
            o_out.sysex_byte == 8'd0 && o_out.message_length == '0 && o_out.last_of_run)
        else $error("non-SysEx result with SysEx fields set");

    // A SysEx byte result has a nonzero length that fits the store.
    a_sysex_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out.event_kind == KIND_SYSEX_BYTE |->
            o_out.message_length != '0 && o_out.message_length <= FILL_W'(SYSEX_MAX - 2))
        else $error("SysEx message length out of range");

endmodule

/* test/usb_midi_result_checker.sv */
// Watches both request channels of the USB-MIDI packet decoder, keeps its own
// model of the SysEx buffer and compares every result request with what the
// accepted packets should have produced, oldest first.
module usb_midi_result_checker #(
    parameter int SYSEX_MAX = 64
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    input  logic                  i_in_stall,
    input  usbmidi_pkg::t_in_req  i_in,
    input  logic                  i_out_valid,
    input  logic                  i_out_stall,
    input  usbmidi_pkg::t_out_req i_out,
    output int                    o_pending,
    output int                    o_mismatches
);
    import usbmidi_pkg::*;

    localparam int AW = $clog2(SYSEX_MAX);

    logic [7:0]        sysex_bytes [SYSEX_MAX];
    logic [FILL_W-1:0] fill_level;
    t_out_req          expected_results [$];
    int                mismatches = 0;
    int                results_seen = 0;

    // One expected result request; channel and raw bytes always come from the packet.
    function automatic t_out_req shape_result(t_kind kind, t_in_req pkt, logic [7:0] sx,
                                              logic [FILL_W-1:0] len, logic last);
        t_out_req r;
        r.event_kind     = kind;
        r.channel_number = {1'b0, pkt.byte0[3:0]} + 5'd1;
        r.out_status     = pkt.byte0;
        r.out_data1      = pkt.byte1;
        r.out_data2      = pkt.byte2;
        r.sysex_byte     = sx;
        r.message_length = len;
        r.last_of_run    = last;
        return r;
    endfunction

    task automatic push_event(input t_kind kind, input t_in_req pkt);
        expected_results.push_back(shape_result(kind, pkt, 8'h00, '0, 1'b1));
    endtask

    // Callers check for room first, so the level never reaches the buffer size here.
    task automatic store_byte(input logic [7:0] b);
        sysex_bytes[fill_level[AW-1:0]] = b;
        fill_level = fill_level + 1'b1;
    endtask

    // SysEx end: append the tail bytes and play back the whole message, or
    // report an overflow and start over when the tail does not fit.
    task automatic close_message(input t_in_req pkt, input int n);
        logic [7:0]        tail [3];
        logic [FILL_W-1:0] len;
        tail[0] = pkt.byte0;
        tail[1] = pkt.byte1;
        tail[2] = pkt.byte2;
        if (int'(fill_level) >= SYSEX_MAX - 1 - n) begin
            fill_level = '0;
            push_event(KIND_OVERFLOW, pkt);
        end else begin
            for (int k = 0; k < n; k++)
                store_byte(tail[k]);
            len = fill_level;
            for (int k = 0; k < int'(len); k++)
                expected_results.push_back(shape_result(KIND_SYSEX_BYTE, pkt,
                                                        sysex_bytes[AW'(k)],
                                                        len, k == int'(len) - 1));
            fill_level = '0;
        end
    endtask

    // Decode one accepted packet by its code index number.
    task automatic predict_packet(input t_in_req pkt);
        case (pkt.packet_header[3:0])
            CODE_NOTE_START:   push_event(KIND_NOTE_ON, pkt);
            CODE_NOTE_RELEASE: push_event(KIND_NOTE_OFF, pkt);
            CODE_CTRL_CHANGE:  push_event(KIND_CC, pkt);
            CODE_PROG_CHANGE:  push_event(KIND_PROGRAM, pkt);
            CODE_BEND_WHEEL:   push_event(KIND_BEND, pkt);
            CODE_AFTERTOUCH:   push_event(KIND_PRESSURE, pkt);
            CODE_SYS_COMMON2, CODE_SYS_COMMON3: push_event(KIND_SYS_COMMON, pkt);
            CODE_ONE_BYTE:     push_event(KIND_SINGLE_BYTE, pkt);
            CODE_SYSEX_START: begin
                // Without room the three bytes are silently dropped.
                if (int'(fill_level) < SYSEX_MAX - 4) begin
                    store_byte(pkt.byte0);
                    store_byte(pkt.byte1);
                    store_byte(pkt.byte2);
                end
            end
            CODE_SYSEX_END3:   close_message(pkt, 3);
            CODE_SYSEX_END2:   close_message(pkt, 2);
            CODE_SYSEX_END1: begin
                // A one-byte packet only ends SysEx when it carries the end byte.
                if (pkt.byte0 == SYSEX_END_BYTE) begin
                    close_message(pkt, 1);
                end else begin
                    push_event(KIND_SYS_COMMON, pkt);
                end
            end
            default:           push_event(KIND_UNSUPPORTED, pkt);
        endcase
    endtask

    task automatic check_field(input string name, input logic [7:0] want,
                               input logic [7:0] got);
        if (got !== want) begin
            mismatches++;
            if (mismatches <= 10)
                $display("result %0d: %s expected %0h, got %0h", results_seen, name, want, got);
        end
    endtask

    task automatic check_result(input t_out_req got);
        t_out_req want;
        if (expected_results.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
                $display("result %0d: none expected, got %h", results_seen, got);
        end else begin
            want = expected_results.pop_front();
            check_field("event_kind", 8'(want.event_kind), 8'(got.event_kind));
            check_field("channel_number", 8'(want.channel_number), 8'(got.channel_number));
            check_field("out_status", want.out_status, got.out_status);
            check_field("out_data1", want.out_data1, got.out_data1);
            check_field("out_data2", want.out_data2, got.out_data2);
            check_field("sysex_byte", want.sysex_byte, got.sysex_byte);
            check_field("message_length", 8'(want.message_length), 8'(got.message_length));
            check_field("last_of_run", 8'(want.last_of_run), 8'(got.last_of_run));
        end
        results_seen++;
    endtask

    // Results are checked before the packet of the same edge is decoded; a packet
    // can never produce a result on the edge that accepts it.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            fill_level = '0;
            expected_results.delete();
        end else begin
            if (i_out_valid && !i_out_stall)
                check_result(i_out);
            if (i_in_valid && !i_in_stall)
                predict_packet(i_in);
        end
        o_pending    <= expected_results.size();
        o_mismatches <= mismatches;
    end

endmodule

/* test/tb_usb_midi_packet_decoder_core.sv */
// Drives USB-MIDI event packets into the decoder with random gaps and output
// stalls; the checker beside the block predicts and compares every result.
module tb_usb_midi_packet_decoder_core;
    import usbmidi_pkg::*;

    // Code index numbers the block treats as unsupported.
    localparam logic [3:0] CODE_MISC          = 4'h0;
    localparam logic [3:0] CODE_CABLE_EVENT   = 4'h1;
    localparam logic [3:0] CODE_POLY_PRESSURE = 4'hA;

    localparam int PACKET_TARGET = 170;
    localparam int CALM_TAIL     = 30;
    localparam int LONG_HOLD     = 300;
    localparam int QUIET_LIMIT   = 3000;
    localparam int SETTLE_CYCLES = 40;

    logic     clk       = 1'b0;
    logic     rst_n     = 1'b0;
    logic     in_valid  = 1'b0;
    logic     in_stall;
    t_in_req  in_pkt    = '0;
    logic     out_valid;
    logic     out_stall = 1'b0;
    t_out_req out_res;
    int       pending;
    int       mismatches;
    bit       idling       = 1'b0;
    bit       hold_go      = 1'b0;
    int       packets_sent = 0;
    int       quiet_cycles = 0;

    usb_midi_packet_decoder_core uut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in        (in_pkt),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out       (out_res)
    );

    usb_midi_result_checker u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .i_in_stall   (in_stall),
        .i_in         (in_pkt),
        .i_out_valid  (out_valid),
        .i_out_stall  (out_stall),
        .i_out        (out_res),
        .o_pending    (pending),
        .o_mismatches (mismatches)
    );

    always begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Watchdog: too long without any request moving on either channel.
    always @(posedge clk) begin
        if (rst_n && !((in_valid && !in_stall) || (out_valid && !out_stall))) begin
            quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("end of test: mismatches");
                $finish;
            end
        end else begin
            quiet_cycles = 0;
        end
    end

    // Receiver: random stall bursts while idling is on, and one long hold on request.
    initial begin
        int burst;
        forever begin
            @(posedge clk);
            if (hold_go) begin
                hold_go = 1'b0;
                out_stall <= 1'b1;
                for (int c = 0; c < LONG_HOLD; c++)
                    @(posedge clk);
                out_stall <= 1'b0;
            end else if (idling && $urandom_range(0, 5) == 0) begin
                burst = $urandom_range(1, 17);
                out_stall <= 1'b1;
                repeat (burst) @(posedge clk);
                out_stall <= 1'b0;
            end
        end
    end

    function automatic t_in_req make_packet(logic [3:0] cin, logic [3:0] cable,
                                            logic [7:0] b0, logic [7:0] b1, logic [7:0] b2);
        t_in_req p;
        p.packet_header = {cable, cin};
        p.byte0         = b0;
        p.byte1         = b1;
        p.byte2         = b2;
        return p;
    endfunction

    // Offer one packet request, possibly after an idle burst, and wait until taken.
    task automatic send_packet(input t_in_req pkt);
        int gap;
        if (idling && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 17);
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_pkt   <= pkt;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        packets_sent++;
    endtask

    task automatic send_random_packet();
        send_packet(make_packet(4'($urandom), 4'($urandom), 8'($urandom), 8'($urandom),
                                8'($urandom)));
    endtask

    // The checker's pending count is registered, so always look past the current edge.
    task automatic wait_drained();
        @(posedge clk);
        while (pending != 0) @(posedge clk);
    endtask

    // A SysEx message: some start packets, now and then a stray event between them,
    // and usually an end packet. Long runs can fill the buffer to overflow.
    task automatic send_sysex_run();
        int starts;
        case ($urandom_range(0, 5))
            0:       starts = $urandom_range(18, 23);
            1:       starts = 0;
            default: starts = $urandom_range(1, 6);
        endcase
        repeat (starts) begin
            send_packet(make_packet(CODE_SYSEX_START, 4'($urandom), 8'($urandom),
                                    8'($urandom), 8'($urandom)));
            if ($urandom_range(0, 9) == 0)
                send_random_packet();
        end
        case ($urandom_range(0, 6))
            0, 1: send_packet(make_packet(CODE_SYSEX_END1, 4'($urandom), SYSEX_END_BYTE,
                                          8'($urandom), 8'($urandom)));
            2, 3: send_packet(make_packet(CODE_SYSEX_END2, 4'($urandom), 8'($urandom),
                                          8'($urandom), 8'($urandom)));
            4, 5: send_packet(make_packet(CODE_SYSEX_END3, 4'($urandom), 8'($urandom),
                                          8'($urandom), 8'($urandom)));
            default: ;  // left open; the next run keeps appending
        endcase
    endtask

    initial begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Every code index number at least once, with extreme bytes and cable numbers.
        send_packet(make_packet(CODE_NOTE_START, 4'h0, 8'h90, 8'h00, 8'h00));
        send_packet(make_packet(CODE_NOTE_START, 4'hF, 8'hFF, 8'hFF, 8'hFF));
        send_packet(make_packet(CODE_NOTE_RELEASE, 4'h5, 8'h8F, 8'h7F, 8'h40));
        send_packet(make_packet(CODE_CTRL_CHANGE, 4'hA, 8'hB3, 8'h07, 8'h64));
        send_packet(make_packet(CODE_PROG_CHANGE, 4'h1, 8'hC0, 8'h05, 8'h00));
        send_packet(make_packet(CODE_BEND_WHEEL, 4'h2, 8'hE7, 8'h00, 8'h40));
        send_packet(make_packet(CODE_AFTERTOUCH, 4'h3, 8'hD9, 8'h33, 8'h00));
        send_packet(make_packet(CODE_SYS_COMMON2, 4'h4, 8'hF3, 8'h01, 8'h00));
        send_packet(make_packet(CODE_SYS_COMMON3, 4'h6, 8'hF2, 8'h10, 8'h20));
        send_packet(make_packet(CODE_ONE_BYTE, 4'h7, 8'hF8, 8'h00, 8'h00));
        send_packet(make_packet(CODE_MISC, 4'h8, 8'h12, 8'h34, 8'h56));
        send_packet(make_packet(CODE_CABLE_EVENT, 4'h9, 8'hAB, 8'hCD, 8'hEF));
        send_packet(make_packet(CODE_POLY_PRESSURE, 4'hB, 8'hA1, 8'h3C, 8'h7F));
        // One-byte packet without the end byte is a system common message.
        send_packet(make_packet(CODE_SYSEX_END1, 4'hC, 8'hF6, 8'h00, 8'h00));
        // Shortest messages: an end byte alone, and two bytes from an empty buffer.
        send_packet(make_packet(CODE_SYSEX_END1, 4'hD, SYSEX_END_BYTE, 8'h00, 8'h00));
        send_packet(make_packet(CODE_SYSEX_END2, 4'hE, 8'hF0, SYSEX_END_BYTE, 8'h00));
        send_packet(make_packet(CODE_SYSEX_START, 4'h0, 8'hF0, 8'h7E, 8'h00));
        send_packet(make_packet(CODE_SYSEX_END3, 4'h0, 8'h06, 8'h01, SYSEX_END_BYTE));
        send_packet(make_packet(CODE_SYSEX_START, 4'hF, 8'hF0, 8'h00, 8'hFF));
        send_packet(make_packet(CODE_SYSEX_START, 4'hF, 8'h80, 8'h7F, 8'h01));
        send_packet(make_packet(CODE_SYSEX_END1, 4'hF, SYSEX_END_BYTE, 8'hFF, 8'hFF));
        in_valid <= 1'b0;
        wait_drained();

        // Long output hold while packets keep coming, so the input side backs up.
        hold_go = 1'b1;
        repeat (12)
            send_packet(make_packet(CODE_NOTE_START, 4'($urandom), 8'($urandom),
                                    8'($urandom), 8'($urandom)));
        in_valid <= 1'b0;
        wait_drained();

        // Random traffic, mostly SysEx runs; the tail runs with no idling at all.
        idling = 1'b1;
        while (packets_sent < PACKET_TARGET) begin
            if (packets_sent >= PACKET_TARGET - CALM_TAIL) begin
                idling = 1'b0;
            end else if ($urandom_range(0, 7) == 0) begin
                idling = !idling;
            end
            if ($urandom_range(0, 9) < 6) begin
                send_sysex_run();
            end else begin
                send_random_packet();
            end
            if (idling && $urandom_range(0, 14) == 0) begin
                in_valid <= 1'b0;
                wait_drained();
            end
        end
        in_valid <= 1'b0;
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);

        if (mismatches == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule

/* usb_midi_packet_decoder_core.f */
src/usbmidi_pkg.sv
src/usbmidi_ram.sv
src/usbmidi_front.sv
src/usbmidi_queue.sv
src/usbmidi_back.sv
src/usb_midi_packet_decoder_core.sv
test/usb_midi_result_checker.sv
test/tb_usb_midi_packet_decoder_core.sv
